@@ design/lmsd_pkg.sv @@
// ----------------------------------------------------------------------------
// LED matrix sigma-delta scan package
// Shared item types, operation codes and sequencer states of the scanner.
// ----------------------------------------------------------------------------
package lmsd_pkg;

  // Columns driven by one module; the driver word is eight bits wide
  localparam int COLS_PER_MOD = 8;
  localparam int PIX_W        = 8;

  // Operation codes of an input item
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [2:0] pixel_row;
    logic [4:0] pixel_column;
    logic [7:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  module_index;
    logic [3:0]  row_address;
    logic [7:0]  column_bits;
    logic        last_of_row;
    logic        frame_end;
    logic [15:0] frame_number;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WORD
  } lmsd_state_e;

endpackage

@@ design/lmsd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lmsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/led_matrix_sigma_delta_scan_top.sv @@
// A pixel write leaves the scanner idle; the input stays ready for the next item.
// A tick reads eight accumulator and brightness pairs per module word through one
// adder, then finishes the word and hands it to the output register, waiting in
// the word state while the output is stalled. No item is taken during a tick.
// After reset a clearing pass over ROWS * MODULES * 8 addresses (256 by default)
// zeroes both memories; no item is taken until it ends.
// ----------------------------------------------------------------------------
// LED matrix sigma-delta scanner, top level
// Stores pixel brightness and scans one row per tick with first-order sigma-delta
// modulation, one pixel per cycle through a shared adder unless the output stalls.
// ----------------------------------------------------------------------------
module led_matrix_sigma_delta_scan_top #(
  parameter int ROWS    = 8,
  parameter int MODULES = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lmsd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lmsd_pkg::out_item_t out_data_o
);

  import lmsd_pkg::*;

  localparam int TOTAL_COLS = MODULES * COLS_PER_MOD;
  localparam int DEPTH      = ROWS * TOTAL_COLS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int MOD_W      = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int COL_W      = $clog2(COLS_PER_MOD);

  lmsd_state_e state_q, state_d;

  logic [ADDR_W-1:0] addr_q;       // clearing and scan address, linear
  logic [ADDR_W-1:0] wb_addr_q;    // address of the read in flight
  logic              pend_q;       // read data arrive this cycle
  logic [COL_W-1:0]  col_q;
  logic [MOD_W-1:0]  mod_q;
  logic [ROW_W-1:0]  row_q;
  logic [15:0]       frame_q;
  logic [7:0]        bits_q;
  logic              out_valid_q;
  out_item_t         out_data_q;

  // Sequencer controls
  logic              issue;
  logic              clr_we;
  logic              load_out;
  logic              addr_wrap;
  logic              col_last;
  logic              mod_last;
  logic              row_last;
  logic              pix_we;
  logic              out_free;

  // Datapath
  logic [ADDR_W-1:0] pix_addr;
  logic [PIX_W-1:0]  acc_rd;
  logic [PIX_W-1:0]  bri_rd;
  logic [PIX_W:0]    sum;

  logic              bri_we;
  logic [ADDR_W-1:0] bri_waddr;
  logic [PIX_W-1:0]  bri_wdata;
  logic              acc_we;
  logic [ADDR_W-1:0] acc_waddr;
  logic [PIX_W-1:0]  acc_wdata;

  assign addr_wrap = (addr_q == ADDR_W'(DEPTH - 1));
  assign col_last  = (col_q == COL_W'(COLS_PER_MOD - 1));
  assign mod_last  = (mod_q == MOD_W'(MODULES - 1));
  assign row_last  = (row_q == ROW_W'(ROWS - 1));
  assign out_free  = !out_valid_q || out_ready_i;

  // Pixel write address and range check
  assign pix_addr = ADDR_W'(ADDR_W'(in_data_i.pixel_row) * ADDR_W'(TOTAL_COLS)
                    + ADDR_W'(in_data_i.pixel_column));
  assign pix_we   = in_valid_i && in_ready_o && (in_data_i.operation == OP_WRITE)
                    && (int'(in_data_i.pixel_row) < ROWS)
                    && (int'(in_data_i.pixel_column) < TOTAL_COLS);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (addr_wrap) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i && in_data_i.operation == OP_TICK) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (col_last) state_d = ST_WORD;
      end
      ST_WORD: begin
        if (load_out) state_d = mod_last ? ST_IDLE : ST_SCAN;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    clr_we     = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_CLEAR: clr_we     = 1'b1;
      ST_IDLE:  in_ready_o = 1'b1;
      ST_SCAN:  issue      = 1'b1;
      ST_WORD:  load_out   = !pend_q && out_free;
      default: ;
    endcase
  end

  // Shared adder: accumulator plus brightness, carry is the LED bit
  assign sum = {1'b0, acc_rd} + {1'b0, bri_rd};

  // Memory write muxing
  always_comb begin
    bri_we    = clr_we || pix_we;
    bri_waddr = clr_we ? addr_q : pix_addr;
    bri_wdata = clr_we ? '0 : in_data_i.pixel_value;
    acc_we    = clr_we || pend_q;
    acc_waddr = clr_we ? addr_q : wb_addr_q;
    acc_wdata = clr_we ? '0 : sum[PIX_W-1:0];
  end

  lmsd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_bri_ram (
    .clk_i   (clk_i),
    .we_i    (bri_we),
    .waddr_i (bri_waddr),
    .wdata_i (bri_wdata),
    .re_i    (issue),
    .raddr_i (addr_q),
    .rdata_o (bri_rd)
  );

  lmsd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (issue),
    .raddr_i (addr_q),
    .rdata_o (acc_rd)
  );

  // Control registers: state, counters, frame count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      addr_q  <= '0;
      pend_q  <= 1'b0;
      col_q   <= '0;
      mod_q   <= '0;
      row_q   <= '0;
      frame_q <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= issue;
      // Advance the linear address on every clear write and every scan read
      if (clr_we || issue) begin
        addr_q <= addr_wrap ? '0 : addr_q + ADDR_W'(1);
      end
      if (issue) begin
        col_q <= col_q + COL_W'(1);
      end
      // Step module, row and frame as each word is loaded into the output register
      if (load_out) begin
        if (mod_last) begin
          mod_q <= '0;
          if (row_last) begin
            row_q   <= '0;
            frame_q <= frame_q + 16'd1;
          end else begin
            row_q <= row_q + ROW_W'(1);
          end
        end else begin
          mod_q <= mod_q + MOD_W'(1);
        end
      end
    end
  end

  // Writeback address and column bit shift
  always_ff @(posedge clk_i) begin
    if (issue) begin
      wb_addr_q <= addr_q;
    end
    if (pend_q) begin
      bits_q <= {bits_q[6:0], sum[PIX_W]};
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q.module_index <= 2'(mod_q);
      out_data_q.row_address  <= 4'(row_q) + 4'd1;
      out_data_q.column_bits  <= bits_q;
      out_data_q.last_of_row  <= mod_last;
      out_data_q.frame_end    <= mod_last && row_last;
      out_data_q.frame_number <= (mod_last && row_last) ? frame_q : 16'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ dv/lmsd_scan_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED matrix scanner checker
// Watches both channels of the scanner. Keeps its own copy of the pixel
// brightness, the modulator accumulators, the scan row and the frame count,
// works out the four driver words of every accepted tick and compares each
// output transfer against the oldest word still owed.
// ----------------------------------------------------------------------------
module lmsd_scan_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  lmsd_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  lmsd_pkg::out_item_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  import lmsd_pkg::*;

  localparam int N_ROWS = 8;
  localparam int N_MODS = 4;
  localparam int N_COLS = N_MODS * COLS_PER_MOD;

  // Pixel state as the scanner should hold it
  logic [PIX_W-1:0] level_mem [N_ROWS][N_COLS];
  logic [PIX_W-1:0] acc_mem   [N_ROWS][N_COLS];
  logic [2:0]       row_q;
  logic [15:0]      frame_q;

  out_item_t        owed_words [$];

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    fail_count_o++;
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  // Scan the current row: one word per module, carries become the on bits
  task automatic predict_row_words();
    out_item_t  word;
    logic [8:0] sum;
    logic [7:0] bits;
    int         x;
    x = 0;
    for (int m = 0; m < N_MODS; m++) begin
      bits = '0;
      for (int c = 0; c < COLS_PER_MOD; c++) begin
        sum = {1'b0, acc_mem[row_q][x]} + {1'b0, level_mem[row_q][x]};
        acc_mem[row_q][x] = sum[7:0];
        bits = {bits[6:0], sum[8]};
        x++;
      end
      word = '0;
      word.module_index = m[1:0];
      word.row_address  = {1'b0, row_q} + 4'd1;
      word.column_bits  = bits;
      if (m == N_MODS - 1) begin
        word.last_of_row = 1'b1;
        if (row_q == 3'(N_ROWS - 1)) begin
          word.frame_end    = 1'b1;
          word.frame_number = frame_q;
        end
      end
      owed_words.push_back(word);
    end
    // Advance the row; wrap and count the frame after the last one
    if (row_q == 3'(N_ROWS - 1)) begin
      row_q   = '0;
      frame_q = frame_q + 16'd1;
    end else begin
      row_q = row_q + 3'd1;
    end
  endtask

  task automatic check_word(input out_item_t got);
    out_item_t want;
    if (owed_words.size() == 0) begin
      report_mismatch("output with no word owed", 16'(got.column_bits), 16'h0);
      return;
    end
    want = owed_words.pop_front();
    if (got.module_index !== want.module_index)
      report_mismatch("module_index", 16'(got.module_index), 16'(want.module_index));
    if (got.row_address !== want.row_address)
      report_mismatch("row_address", 16'(got.row_address), 16'(want.row_address));
    if (got.column_bits !== want.column_bits)
      report_mismatch("column_bits", 16'(got.column_bits), 16'(want.column_bits));
    if (got.last_of_row !== want.last_of_row)
      report_mismatch("last_of_row", 16'(got.last_of_row), 16'(want.last_of_row));
    if (got.frame_end !== want.frame_end)
      report_mismatch("frame_end", 16'(got.frame_end), 16'(want.frame_end));
    if (got.frame_number !== want.frame_number)
      report_mismatch("frame_number", got.frame_number, want.frame_number);
  endtask

  initial fail_count_o = 0;

  // Outputs are checked before the input of the same edge is modelled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < N_ROWS; r++) begin
        for (int c = 0; c < N_COLS; c++) begin
          level_mem[r][c] = '0;
          acc_mem[r][c]   = '0;
        end
      end
      row_q   = '0;
      frame_q = '0;
      owed_words.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_word(out_data_i);
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.operation == OP_TICK) begin
          predict_row_words();
        end else if (int'(in_data_i.pixel_row) < N_ROWS &&
                     int'(in_data_i.pixel_column) < N_COLS) begin
          level_mem[in_data_i.pixel_row][in_data_i.pixel_column] = in_data_i.pixel_value;
        end
      end
    end
    pending_o = owed_words.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED matrix scanner testbench
// Sends pixel writes and scan ticks with random gaps and output back-pressure,
// first a directed frame over extreme pixels, then a random mix with a calm
// stretch and a full drain. The checker predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_top;
  import lmsd_pkg::*;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  int        fail_count;
  int        pending;
  logic      calm = 1'b0;

  always #1 clk_i = ~clk_i;

  led_matrix_sigma_delta_scan_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  lmsd_scan_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Stall the output at random, except through the calm stretch
  always @(negedge clk_i) begin
    out_ready_i <= calm ? 1'b1 : ($urandom_range(0, 99) >= 38);
  end

  // Idle the input for a random number of cycles, then hold one item until transfer
  task automatic send_item(input logic op, input logic [2:0] row, input logic [4:0] col,
                           input logic [7:0] level);
    in_item_t item;
    item.operation    = op;
    item.pixel_row    = row;
    item.pixel_column = col;
    item.pixel_value  = level;
    while (!calm && $urandom_range(0, 99) < 38) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corner pixels and extreme levels, then a full frame and a bit more
    send_item(OP_WRITE, 3'd0, 5'd0,  8'd255);
    send_item(OP_WRITE, 3'd0, 5'd31, 8'h80);
    send_item(OP_WRITE, 3'd0, 5'd7,  8'd1);
    send_item(OP_WRITE, 3'd0, 5'd8,  8'd127);
    send_item(OP_WRITE, 3'd7, 5'd31, 8'd255);
    send_item(OP_WRITE, 3'd7, 5'd0,  8'd170);
    send_item(OP_WRITE, 3'd3, 5'd16, 8'd85);
    send_item(OP_WRITE, 3'd5, 5'd24, 8'd240);
    send_item(OP_TICK,  3'd7, 5'd31, 8'd255);
    for (int i = 0; i < 8; i++) begin
      send_item(OP_TICK, 3'd0, 5'd0, 8'd0);
    end
    send_item(OP_WRITE, 3'd0, 5'd0, 8'd0);
    send_item(OP_TICK,  3'd0, 5'd0, 8'd0);

    // Random mix of writes and ticks
    for (int i = 0; i < 90; i++) begin
      calm = (i >= 30 && i < 60);
      if (i == 80) begin
        // Hold off the next item until every owed word has left
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (pending != 0) @(posedge clk_i);
      end
      send_item(($urandom_range(0, 99) < 45) ? OP_TICK : OP_WRITE,
                3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)), pick_level());
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then let any stray word show up
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
